[rtl/swa_pkg.sv]
// ----------------------------------------------------------------------------
// swa_pkg : sliding window average shared definitions
// Widths, sizes and helpers used across the averaging block.
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;

    localparam int FRAC_W   = 8;
    localparam int AVG_W    = 24;
    localparam int HELD_W   = 7;
    localparam int WSZ_W    = 7;
    localparam int WSZ_RESET = 8;

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W = $clog2(MAX_WINDOW);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int DVD_W  = SUM_W - 1 + FRAC_W;

    localparam int S_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = ((AVG_W + HELD_W + 7) / 8) * 8;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dvd;
        logic [CNT_W-1:0] dsr;
    } t_div_req;

    function automatic logic signed [SUM_W-1:0] sext_sample(
        input logic signed [SAMPLE_BITS-1:0] s
    );
        return SUM_W'(s);
    endfunction

    function automatic logic [CNT_W-1:0] eff_size(input logic [WSZ_W-1:0] wsz);
        logic [CNT_W-1:0] n;
        if (wsz == '0) begin
            n = CNT_W'(1);
        end else if (int'(wsz) > MAX_WINDOW) begin
            n = CNT_W'(MAX_WINDOW);
        end else begin
            n = CNT_W'(wsz);
        end
        return n;
    endfunction

endpackage

[rtl/swa_ram.sv]
// ----------------------------------------------------------------------------
// swa_ram : generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/swa_div.sv]
// ----------------------------------------------------------------------------
// swa_div : radix-2 restoring divider
// Unsigned dividend by small divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swa_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  swa_pkg::t_div_req        i_req,
    output logic                     o_done,
    output logic [swa_pkg::DVD_W-1:0] o_quo
);

    localparam int STEP_W = $clog2(swa_pkg::DVD_W + 1);

    logic [swa_pkg::DVD_W-1:0] r_dvd;
    logic [swa_pkg::CNT_W-1:0] r_rem;
    logic [swa_pkg::CNT_W-1:0] r_dsr;
    logic [STEP_W-1:0]         r_step;
    logic                      r_done;

    logic [swa_pkg::CNT_W:0] trial;
    logic [swa_pkg::CNT_W:0] diff;
    logic                    ge;

    assign trial = {r_rem, r_dvd[swa_pkg::DVD_W-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign ge    = trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_step <= STEP_W'(swa_pkg::DVD_W);
            r_done <= 1'b0;
        end else if (r_step != '0) begin
            r_step <= r_step - 1'b1;
            r_done <= (r_step == STEP_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dvd;
            r_dsr <= i_req.dsr;
            r_rem <= '0;
        end else if (r_step != '0) begin
            r_dvd <= {r_dvd[swa_pkg::DVD_W-2:0], ge};
            r_rem <= ge ? swa_pkg::CNT_W'(diff) : swa_pkg::CNT_W'(trial);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_dvd;

endmodule

[rtl/sliding_window_average.sv]
// ----------------------------------------------------------------------------
// sliding_window_average : moving average over the last N samples
// Ring store in RAM, running sum, shared serial divider for the mean.
// ----------------------------------------------------------------------------
// One request at a time. A push forms its mean in the radix-2 divider, with
// 8 fraction bits. A push on a full window also reads the oldest sample from
// the window RAM. A fill walks the RAM one slot a cycle. A finished result
// sits in the output register while the next request is accepted. Writing
// the window size clears the held count, the running sum and the ring
// position.
module sliding_window_average (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swa_pkg::WSZ_W-1:0]     i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [swa_pkg::S_DATA_W-1:0]  s_axis_tdata,  // sample
    input  logic                          s_axis_tuser,  // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [swa_pkg::M_DATA_W-1:0]  m_axis_tdata   // average, held
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FILL  = 6'b000010,
        S_SUB   = 6'b000100,
        S_DIVGO = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [swa_pkg::WSZ_W-1:0]           r_wsz;
    logic signed [swa_pkg::SUM_W-1:0]    r_sum;
    logic [swa_pkg::CNT_W-1:0]           r_fc;
    logic [swa_pkg::ADDR_W-1:0]          r_pos;
    logic [swa_pkg::ADDR_W-1:0]          r_addr;
    logic [swa_pkg::SAMPLE_BITS-1:0]     r_smp;
    logic [swa_pkg::CNT_W-1:0]           r_dsr;
    logic                                r_neg;
    logic                                r_m_valid;
    logic [swa_pkg::AVG_W-1:0]           r_m_avg;
    logic [swa_pkg::HELD_W-1:0]          r_m_held;

    logic [swa_pkg::CNT_W-1:0]           eff_n;
    logic [swa_pkg::ADDR_W-1:0]          last_addr;
    logic                                accept;
    logic                                op;
    logic [swa_pkg::SAMPLE_BITS-1:0]     in_smp;
    logic                                filling;
    logic                                out_free;

    logic                                ram_we;
    logic [swa_pkg::ADDR_W-1:0]          ram_waddr;
    logic [swa_pkg::SAMPLE_BITS-1:0]     ram_wdata;
    logic                                ram_re;
    logic [swa_pkg::SAMPLE_BITS-1:0]     ram_rdata;

    logic signed [swa_pkg::SUM_W-1:0]    sum_abs;
    swa_pkg::t_div_req                   div_req;
    logic                                div_done;
    logic [swa_pkg::DVD_W-1:0]           div_quo;
    logic signed [swa_pkg::DVD_W:0]      quo_ext;
    logic signed [swa_pkg::DVD_W:0]      avg_full;

    assign eff_n     = swa_pkg::eff_size(r_wsz);
    assign last_addr = swa_pkg::ADDR_W'(eff_n - 1'b1);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign op        = s_axis_tuser;
    assign in_smp    = s_axis_tdata[swa_pkg::SAMPLE_BITS-1:0];
    assign filling   = r_fc < eff_n;
    assign out_free  = !r_m_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);

    // window RAM ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_smp;
        ram_re    = 1'b0;
        if (accept && !op && filling) begin
            ram_we    = 1'b1;
            ram_waddr = swa_pkg::ADDR_W'(r_fc);
            ram_wdata = in_smp;
        end else if (accept && !op) begin
            ram_re = 1'b1;
        end else if (r_state == S_FILL) begin
            ram_we    = 1'b1;
            ram_waddr = r_addr;
        end else if (r_state == S_SUB) begin
            ram_we = 1'b1;
        end
    end

    swa_ram #(
        .WIDTH (swa_pkg::SAMPLE_BITS),
        .DEPTH (swa_pkg::MAX_WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    assign sum_abs = r_sum[swa_pkg::SUM_W-1] ? -r_sum : r_sum;

    always_comb begin
        div_req.start = (r_state == S_DIVGO);
        div_req.dvd   = {sum_abs[swa_pkg::SUM_W-2:0], {swa_pkg::FRAC_W{1'b0}}};
        div_req.dsr   = r_dsr;
    end

    swa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign quo_ext  = {1'b0, div_quo};
    assign avg_full = r_neg ? -quo_ext : quo_ext;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (op) begin
                        n_state = S_FILL;
                    end else if (filling) begin
                        n_state = S_DIVGO;
                    end else begin
                        n_state = S_SUB;
                    end
                end
            end
            S_FILL: begin
                if (r_addr == last_addr) begin
                    n_state = S_DIVGO;
                end
            end
            S_SUB:   n_state = S_DIVGO;
            S_DIVGO: n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wsz     <= swa_pkg::WSZ_W'(swa_pkg::WSZ_RESET);
            r_sum     <= '0;
            r_fc      <= '0;
            r_pos     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_wsz <= i_cfg_wdata;
                r_sum <= '0;
                r_fc  <= '0;
                r_pos <= '0;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (accept) begin
                            if (op) begin
                                r_sum <= '0;
                            end else begin
                                r_sum <= r_sum + swa_pkg::sext_sample(in_smp);
                                if (filling) begin
                                    r_fc <= r_fc + 1'b1;
                                end
                            end
                        end
                    end
                    S_FILL: begin
                        r_sum <= r_sum + swa_pkg::sext_sample(r_smp);
                        if (r_addr == last_addr) begin
                            r_fc  <= eff_n;
                            r_pos <= '0;
                        end
                    end
                    S_SUB: begin
                        r_sum <= r_sum - swa_pkg::sext_sample(ram_rdata);
                        r_pos <= (r_pos == last_addr) ? '0 : r_pos + 1'b1;
                    end
                    S_DIVGO, S_DIV, S_OUT: begin
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_smp  <= in_smp;
            r_addr <= '0;
            if (!op && filling) begin
                r_dsr <= r_fc + 1'b1;
            end else begin
                r_dsr <= eff_n;
            end
        end else if (r_state == S_FILL) begin
            r_addr <= r_addr + 1'b1;
        end
        if (r_state == S_DIVGO) begin
            r_neg <= r_sum[swa_pkg::SUM_W-1];
        end
        if (r_state == S_OUT && out_free) begin
            r_m_avg  <= swa_pkg::AVG_W'(avg_full);
            r_m_held <= swa_pkg::HELD_W'(r_dsr);
        end
    end

    assign m_axis_tvalid = r_m_valid;

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[swa_pkg::AVG_W-1:0]              = r_m_avg;
        m_axis_tdata[swa_pkg::AVG_W +: swa_pkg::HELD_W] = r_m_held;
    end

endmodule

[rtl/swa_checker.sv]
// ----------------------------------------------------------------------------
// swa_checker : port-level checks for the sliding window average
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module swa_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [swa_pkg::M_DATA_W-1:0] m_axis_tdata
);

    logic [swa_pkg::HELD_W-1:0] held;
    assign held = m_axis_tdata[swa_pkg::AVG_W +: swa_pkg::HELD_W];

    // one request in flight: no acceptance in the cycle after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while previous one in progress");

    // a fresh result only appears after the input side was busy
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without processing");

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (held != '0) &&
                          (int'(held) <= swa_pkg::MAX_WINDOW))
        else $error("held count out of range");

    a_stall_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind sliding_window_average swa_checker u_swa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
